// ===== src/ddspg_pkg.sv =====
`default_nettype none

package ddspg_pkg;

    // field widths
    localparam int RATE_W  = 20;
    localparam int SPEED_W = 21;
    localparam int PHASE_W = 21;
    localparam int CFG_W   = 2;

    // reset and saturation values
    localparam logic [RATE_W-1:0]  TICK_RATE_RST = RATE_W'(20000);
    localparam logic [PHASE_W-1:0] PHASE_MAX     = {PHASE_W{1'b1}};

    // request operation codes
    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_SET_SPEEDS = 2'd1,
        OP_ENABLE     = 2'd2,
        OP_DISABLE    = 2'd3
    } op_t;

    // configuration register indexes
    typedef enum logic [CFG_W-1:0] {
        CFG_TICK_RATE        = 2'd0,
        CFG_LEFT_DIR_INVERT  = 2'd1,
        CFG_RIGHT_DIR_INVERT = 2'd2
    } cfg_idx_t;

    // command from the input stage to each channel
    typedef struct packed {
        logic fire;
        op_t  op;
    } cmd_t;

endpackage

`default_nettype wire

// ===== src/ddspg_channel.sv =====
`default_nettype none

module ddspg_channel (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire ddspg_pkg::cmd_t                     cmd,
    input  wire logic signed [ddspg_pkg::SPEED_W-1:0] speed,
    input  wire logic [ddspg_pkg::RATE_W-1:0]        tick_rate,
    output logic                                     step,
    output logic                                     forward
);
    import ddspg_pkg::*;

    logic [RATE_W-1:0]  rate_mag_reg;
    logic [RATE_W-1:0]  rate_mag_next;
    logic               forward_reg;
    logic               forward_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;

    logic               speed_neg;
    logic [SPEED_W-1:0] speed_abs;
    logic [RATE_W-1:0]  load_mag;
    logic               load_fwd;
    logic [PHASE_W:0]   sum;
    logic [PHASE_W:0]   sum_adj;
    logic               hit;
    logic [PHASE_W-1:0] phase_adv;

    // clamp the signed speed to plus or minus the tick rate
    always_comb
    begin
        speed_neg = speed[SPEED_W-1];
        speed_abs = speed_neg ? SPEED_W'(-speed) : SPEED_W'(speed);
        if (speed_abs > {1'b0, tick_rate})
            load_mag = tick_rate;
        else
            load_mag = speed_abs[RATE_W-1:0];
        load_fwd = !speed_neg || (load_mag == '0);
    end

    // phase accumulate, threshold subtract, saturate
    always_comb
    begin
        sum     = {1'b0, phase_reg} + {{(PHASE_W+1-RATE_W){1'b0}}, rate_mag_reg};
        hit     = sum >= {{(PHASE_W+1-RATE_W){1'b0}}, tick_rate};
        sum_adj = hit ? (sum - {{(PHASE_W+1-RATE_W){1'b0}}, tick_rate}) : sum;
        phase_adv = sum_adj[PHASE_W] ? PHASE_MAX : sum_adj[PHASE_W-1:0];
    end

    // next state per operation
    always_comb
    begin
        rate_mag_next = rate_mag_reg;
        forward_next  = forward_reg;
        phase_next    = phase_reg;
        step          = 1'b0;
        if (cmd.fire)
        begin
            case (cmd.op)
                OP_TICK:
                begin
                    if (rate_mag_reg != '0)
                    begin
                        phase_next = phase_adv;
                        step       = hit;
                    end
                end
                OP_SET_SPEEDS:
                begin
                    rate_mag_next = load_mag;
                    forward_next  = load_fwd;
                end
                OP_DISABLE:
                begin
                    rate_mag_next = '0;
                    phase_next    = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign forward = forward_next;

    // channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_mag_reg <= '0;
            forward_reg  <= 1'b1;
            phase_reg    <= '0;
        end
        else
        begin
            rate_mag_reg <= rate_mag_next;
            forward_reg  <= forward_next;
            phase_reg    <= phase_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/dual_dda_step_pulse_generator_core.sv =====
`default_nettype none

// channel  direction  handshake            payload
// in       input      in_valid / in_stall   operation, left_speed, right_speed
// out      output     out_valid / out_stall left_step, right_step, left_dir_level,
//                                           right_dir_level, drivers_enabled
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one request per clock while not stalled; a request is registered in the input
// stage, processed there, and its result is registered in the output stage,
// which raises out_valid.
// both accumulators update while a request is processed (add, compare, subtract).
// rst_n asynchronously resets all but payload registers; tick rate resets to 20000.
// a stalled result holds the processing stage, which then stalls the input.
// cfg_ready is always high.

module dual_dda_step_pulse_generator_core (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [1:0]                           operation,
    input  wire logic signed [ddspg_pkg::SPEED_W-1:0] left_speed,
    input  wire logic signed [ddspg_pkg::SPEED_W-1:0] right_speed,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      left_step,
    output logic                                      right_step,
    output logic                                      left_dir_level,
    output logic                                      right_dir_level,
    output logic                                      drivers_enabled,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [ddspg_pkg::CFG_W-1:0]          cfg_index,
    input  wire logic [ddspg_pkg::RATE_W-1:0]         cfg_data
);
    import ddspg_pkg::*;

    logic [RATE_W-1:0]  tick_rate_reg;
    logic               left_inv_reg;
    logic               right_inv_reg;

    logic               in_valid_reg;
    op_t                op_reg;
    logic [SPEED_W-1:0] left_speed_reg;
    logic [SPEED_W-1:0] right_speed_reg;

    logic               enabled_reg;
    logic               enabled_next;

    logic               out_valid_reg;
    logic               left_step_reg;
    logic               right_step_reg;
    logic               left_dir_reg;
    logic               right_dir_reg;
    logic               enabled_out_reg;

    logic               advance;
    logic               accept;
    cmd_t               cmd;
    logic               left_step_c;
    logic               right_step_c;
    logic               left_fwd_c;
    logic               right_fwd_c;

    // handshake control
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign cmd.fire = advance;
    assign cmd.op   = op_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_rate_reg <= TICK_RATE_RST;
            left_inv_reg  <= 1'b0;
            right_inv_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TICK_RATE:        tick_rate_reg <= cfg_data;
                CFG_LEFT_DIR_INVERT:  left_inv_reg  <= cfg_data[0];
                CFG_RIGHT_DIR_INVERT: right_inv_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg          <= op_t'(operation);
            left_speed_reg  <= left_speed;
            right_speed_reg <= right_speed;
        end
    end

    // per channel rate, direction and phase
    ddspg_channel u_left (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .speed     (left_speed_reg),
        .tick_rate (tick_rate_reg),
        .step      (left_step_c),
        .forward   (left_fwd_c)
    );

    ddspg_channel u_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .speed     (right_speed_reg),
        .tick_rate (tick_rate_reg),
        .step      (right_step_c),
        .forward   (right_fwd_c)
    );

    // driver enable flag
    always_comb
    begin
        enabled_next = enabled_reg;
        if (advance)
        begin
            case (op_reg)
                OP_ENABLE:  enabled_next = 1'b1;
                OP_DISABLE: enabled_next = 1'b0;
                default:    enabled_next = enabled_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            enabled_reg <= 1'b0;
        else
            enabled_reg <= enabled_next;
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            left_step_reg   <= left_step_c;
            right_step_reg  <= right_step_c;
            left_dir_reg    <= left_fwd_c ^ left_inv_reg;
            right_dir_reg   <= right_fwd_c ^ right_inv_reg;
            enabled_out_reg <= enabled_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign left_step       = left_step_reg;
    assign right_step      = right_step_reg;
    assign left_dir_level  = left_dir_reg;
    assign right_dir_level = right_dir_reg;
    assign drivers_enabled = enabled_out_reg;

endmodule

`default_nettype wire
